// ----- src/sdinit_pkg.sv -----
package sdinit_pkg;

  // input item kinds
  localparam logic IN_START    = 1'b0;
  localparam logic IN_RESPONSE = 1'b1;

  // status codes
  localparam logic [4:0] ST_OK      = 5'd0;
  localparam logic [4:0] ST_TIMEOUT = 5'd1;
  localparam logic [4:0] ST_CRC     = 5'd2;
  localparam logic [4:0] ST_INDEX   = 5'd3;
  localparam logic [4:0] ST_VOLTAGE = 5'd4;
  localparam logic [4:0] ST_R1_BASE = 5'd5;
  localparam logic [4:0] ST_CMD_CRC = 5'd12;
  localparam logic [4:0] ST_ILLEGAL = 5'd13;
  localparam logic [4:0] ST_GENERAL = 5'd16;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID  = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA      = 6'd3;
  localparam logic [5:0] ACMD_BUS_WIDTH    = 6'd6;
  localparam logic [5:0] CMD_SELECT        = 6'd7;
  localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
  localparam logic [5:0] CMD_SET_BLOCKLEN  = 6'd16;
  localparam logic [5:0] ACMD_SEND_OP_COND = 6'd41;
  localparam logic [5:0] CMD_APP           = 6'd55;

  // command arguments
  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [31:0] ARG_OP_COND   = 32'h8010_0000;
  localparam logic [31:0] ARG_HCS       = 32'h4000_0000;
  localparam logic [31:0] ARG_BUS_WIDE  = 32'd2;
  localparam logic [31:0] ARG_BLOCKLEN  = 32'd512;

  // card types
  localparam logic [1:0] TYPE_SDSC_V1 = 2'd0;
  localparam logic [1:0] TYPE_SDSC_V2 = 2'd1;
  localparam logic [1:0] TYPE_SDHC    = 2'd2;

  // csd structure versions
  localparam logic [1:0] CSD_V1 = 2'd0;
  localparam logic [1:0] CSD_V2 = 2'd1;

  localparam logic [15:0] TRIALS_RESET = 16'hffff;
  localparam logic [15:0] TRIALS_SAT   = 16'hffff;

  // r1 error bits in priority order, highest first
  localparam int R1_ERR_COUNT = 19;
  localparam logic [4:0] R1_ERR_BIT [R1_ERR_COUNT] = '{
    5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd24, 5'd23, 5'd22, 5'd21,
    5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd3
  };

  typedef struct packed {
    logic        command;
    logic        timed_out;
    logic        crc_failed;
    logic [5:0]  resp_cmd_index;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic        long_response;
    logic        finished;
    logic [4:0]  status_code;
    logic [1:0]  card_type;
    logic [15:0] card_address;
    logic [31:0] capacity_kb;
  } result_t;

  function automatic logic [4:0] r1_check(logic [5:0] exp_idx, logic to, logic crc,
                                          logic [5:0] idx, logic [31:0] w0);
    logic [4:0] st;
    st = ST_OK;
    if (to) begin
      st = ST_TIMEOUT;
    end else if (crc) begin
      st = ST_CRC;
    end else if (idx != exp_idx) begin
      st = ST_INDEX;
    end else begin
      // walk from lowest priority up so the highest set bit wins
      for (int i = R1_ERR_COUNT - 1; i >= 0; i--) begin
        if (w0[R1_ERR_BIT[i]]) st = ST_R1_BASE + 5'(i);
      end
    end
    return st;
  endfunction

  function automatic logic [4:0] r6_check(logic to, logic crc, logic [5:0] idx,
                                          logic [31:0] w0);
    logic [4:0] st;
    st = ST_OK;
    if (to) begin
      st = ST_TIMEOUT;
    end else if (crc) begin
      st = ST_CRC;
    end else if (idx != CMD_SEND_RCA) begin
      st = ST_INDEX;
    end else if (w0[13]) begin
      st = ST_GENERAL;
    end else if (w0[14]) begin
      st = ST_ILLEGAL;
    end else if (w0[15]) begin
      st = ST_CMD_CRC;
    end
    return st;
  endfunction

  function automatic logic [31:0] csd_capacity(logic [31:0] w0, logic [31:0] w1,
                                               logic [31:0] w2, logic [31:0] old);
    logic [12:0] csize1;
    logic [4:0]  expo;
    logic [31:0] cap;
    csize1 = {1'b0, w1[9:0], w2[31:30]} + 13'd1;
    // c_size_mult + read_bl_len + 2, result shifted relative to 2^10
    expo = {2'b0, w2[17:15]} + {1'b0, w1[19:16]} + 5'd2;
    unique case (w0[31:30])
      CSD_V1: begin
        if (expo >= 5'd10) cap = {19'b0, csize1} << (expo - 5'd10);
        else cap = {19'b0, csize1} >> (5'd10 - expo);
      end
      CSD_V2:  cap = {1'b0, w1[5:0], w2[31:16], 9'b0};
      default: cap = old;
    endcase
    return cap;
  endfunction

endpackage

// ----- src/sdinit_in_stage.sv -----
module sdinit_in_stage import sdinit_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  s_valid,
  output item_t s_item
);

  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item <= in_item;
    end
  end

endmodule

// ----- src/sdinit_core.sv -----
module sdinit_core import sdinit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  item_t       item,
  output result_t     res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD0, PH_CMD8, PH_PRE55, PH_LOOP55, PH_ACMD41, PH_CMD2,
    PH_CMD3, PH_CMD9, PH_CMD7, PH_WB55, PH_ACMD6, PH_CMD16
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  type_reg, type_next;
  logic        high_cap_request, high_cap_next;
  logic [15:0] rca_reg, rca_next;
  logic [15:0] trial_count, trial_next, trial_inc;
  logic [31:0] capacity_reg, capacity_next;
  logic [15:0] max_trials;
  logic [5:0]  r1_idx;
  logic [4:0]  r1_st, r6_st;

  logic        send, fin, lng;
  logic [5:0]  ci;
  logic [31:0] arg;
  logic [4:0]  code;

  always_comb begin
    unique case (phase)
      PH_ACMD6: r1_idx = ACMD_BUS_WIDTH;
      PH_CMD16: r1_idx = CMD_SET_BLOCKLEN;
      default:  r1_idx = CMD_APP;
    endcase
  end

  assign r1_st = r1_check(r1_idx, item.timed_out, item.crc_failed, item.resp_cmd_index,
                          item.resp_word0);
  assign r6_st = r6_check(item.timed_out, item.crc_failed, item.resp_cmd_index,
                          item.resp_word0);
  assign trial_inc = (trial_count == TRIALS_SAT) ? trial_count : trial_count + 16'd1;

  always_comb begin
    phase_next    = phase;
    type_next     = type_reg;
    high_cap_next = high_cap_request;
    rca_next      = rca_reg;
    trial_next    = trial_count;
    capacity_next = capacity_reg;
    send = 1'b0;
    fin  = 1'b0;
    lng  = 1'b0;
    ci   = CMD_GO_IDLE;
    arg  = '0;
    code = ST_OK;

    if (item.command == IN_START) begin
      type_next     = TYPE_SDSC_V1;
      high_cap_next = 1'b0;
      rca_next      = '0;
      trial_next    = '0;
      capacity_next = '0;
      send       = 1'b1;
      phase_next = PH_CMD0;
    end else begin
      unique case (phase)
        PH_CMD0: begin
          if (item.timed_out) begin
            fin = 1'b1; code = ST_TIMEOUT;
          end else begin
            send = 1'b1; ci = CMD_SEND_IF_COND; arg = ARG_IF_COND; phase_next = PH_CMD8;
          end
        end
        PH_CMD8: begin
          // any answer to cmd8 means a v2 card
          if (!item.timed_out) begin
            type_next = TYPE_SDSC_V2; high_cap_next = 1'b1;
          end
          send = 1'b1; ci = CMD_APP; phase_next = PH_PRE55;
        end
        PH_PRE55: begin
          if (r1_st != ST_OK) begin
            fin = 1'b1; code = r1_st;
          end else if (trial_count >= max_trials) begin
            fin = 1'b1; code = ST_VOLTAGE;
          end else begin
            send = 1'b1; ci = CMD_APP; phase_next = PH_LOOP55;
          end
        end
        PH_LOOP55: begin
          if (r1_st != ST_OK) begin
            fin = 1'b1; code = r1_st;
          end else begin
            send = 1'b1; ci = ACMD_SEND_OP_COND;
            arg = ARG_OP_COND | (high_cap_request ? ARG_HCS : 32'd0);
            phase_next = PH_ACMD41;
          end
        end
        PH_ACMD41: begin
          if (item.timed_out) begin
            fin = 1'b1; code = ST_TIMEOUT;
          end else begin
            trial_next = trial_inc;
            // a ready card wins even on the last trial
            if (item.resp_word0[31]) begin
              if (item.resp_word0[30]) type_next = TYPE_SDHC;
              send = 1'b1; ci = CMD_ALL_SEND_CID; lng = 1'b1; phase_next = PH_CMD2;
            end else if (trial_inc >= max_trials) begin
              fin = 1'b1; code = ST_VOLTAGE;
            end else begin
              send = 1'b1; ci = CMD_APP; phase_next = PH_LOOP55;
            end
          end
        end
        PH_CMD2: begin
          if (item.timed_out) begin
            fin = 1'b1; code = ST_TIMEOUT;
          end else if (item.crc_failed) begin
            fin = 1'b1; code = ST_CRC;
          end else begin
            send = 1'b1; ci = CMD_SEND_RCA; phase_next = PH_CMD3;
          end
        end
        PH_CMD3: begin
          if (r6_st != ST_OK) begin
            fin = 1'b1; code = r6_st;
          end else begin
            rca_next = item.resp_word0[31:16];
            send = 1'b1; ci = CMD_SEND_CSD; arg = {item.resp_word0[31:16], 16'b0};
            lng = 1'b1; phase_next = PH_CMD9;
          end
        end
        PH_CMD9: begin
          if (item.timed_out) begin
            fin = 1'b1; code = ST_TIMEOUT;
          end else if (item.crc_failed) begin
            fin = 1'b1; code = ST_CRC;
          end else begin
            capacity_next = csd_capacity(item.resp_word0, item.resp_word1,
                                         item.resp_word2, capacity_reg);
            send = 1'b1; ci = CMD_SELECT; arg = {rca_reg, 16'b0}; phase_next = PH_CMD7;
          end
        end
        PH_CMD7: begin
          send = 1'b1; ci = CMD_APP; arg = {rca_reg, 16'b0}; phase_next = PH_WB55;
        end
        PH_WB55: begin
          if (r1_st != ST_OK) begin
            fin = 1'b1; code = r1_st;
          end else begin
            send = 1'b1; ci = ACMD_BUS_WIDTH; arg = ARG_BUS_WIDE; phase_next = PH_ACMD6;
          end
        end
        PH_ACMD6: begin
          if (r1_st != ST_OK) begin
            fin = 1'b1; code = r1_st;
          end else begin
            send = 1'b1; ci = CMD_SET_BLOCKLEN; arg = ARG_BLOCKLEN; phase_next = PH_CMD16;
          end
        end
        PH_CMD16: begin
          fin = 1'b1; code = r1_st;
        end
        default: begin
          // response with no command outstanding: nothing to do
        end
      endcase
      if (fin) phase_next = PH_IDLE;
    end
  end

  always_comb begin
    res.send_valid    = send;
    res.cmd_index     = ci;
    res.cmd_arg       = arg;
    res.long_response = lng;
    res.finished      = fin;
    res.status_code   = code;
    res.card_type     = type_next;
    res.card_address  = rca_next;
    res.capacity_kb   = capacity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      type_reg         <= TYPE_SDSC_V1;
      high_cap_request <= 1'b0;
      rca_reg          <= '0;
      trial_count      <= '0;
      capacity_reg     <= '0;
      max_trials       <= TRIALS_RESET;
    end else begin
      if (cfg_we) max_trials <= cfg_data;
      if (step) begin
        phase            <= phase_next;
        type_reg         <= type_next;
        high_cap_request <= high_cap_next;
        rca_reg          <= rca_next;
        trial_count      <= trial_next;
        capacity_reg     <= capacity_next;
      end
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.finished |=> phase == PH_IDLE)
    else $error("sequence ended but phase not idle");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    step && item.command == IN_START |=>
      phase == PH_CMD0 && rca_reg == '0 && capacity_reg == '0 &&
      trial_count == '0 && type_reg == TYPE_SDSC_V1 && !high_cap_request)
    else $error("start did not clear card registers");

  a_long_resp: assert property (@(posedge clk) disable iff (rst)
    step && res.long_response |->
      res.send_valid && (res.cmd_index == CMD_ALL_SEND_CID || res.cmd_index == CMD_SEND_CSD))
    else $error("long response flagged on a short-response command");

  a_trial_count: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_ACMD41 && item.command == IN_RESPONSE && !item.timed_out &&
      trial_count != TRIALS_SAT |=> trial_count == $past(trial_count) + 16'd1)
    else $error("voltage trial not counted");

endmodule

// ----- src/sdinit_out_stage.sv -----
module sdinit_out_stage import sdinit_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- src/sd_card_init_sequencer.sv -----
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    command, timed_out, crc_failed, resp_cmd_index,
//                                       resp_word0, resp_word1, resp_word2
// out       out  out_valid / out_ready  send_valid, cmd_index, cmd_arg, long_response,
//                                       finished, status_code, card_type, card_address,
//                                       capacity_kb
// cfg       in   cfg_valid / cfg_ready  cfg_data (max_voltage_trials)
//
// one beat in, one beat out; a result is registered in the output register after its
// input beat has been held in the input register
// sustained rate is one beat per cycle while out_ready is high: the sequencer step is a
// single combinational pass from input to output register, state updates on that pass
// a stalled output register holds its beat; the input register still takes one more beat
// rst is synchronous: phase idle, card registers zero, trial limit 65535
// cfg_ready is always high, the trial limit updates on the next edge
module sd_card_init_sequencer import sdinit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic        timed_out,
  input  logic        crc_failed,
  input  logic [5:0]  resp_cmd_index,
  input  logic [31:0] resp_word0,
  input  logic [31:0] resp_word1,
  input  logic [31:0] resp_word2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send_valid,
  output logic [5:0]  cmd_index,
  output logic [31:0] cmd_arg,
  output logic        long_response,
  output logic        finished,
  output logic [4:0]  status_code,
  output logic [1:0]  card_type,
  output logic [15:0] card_address,
  output logic [31:0] capacity_kb,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  item_t   in_item, s_item;
  result_t core_res, out_res;
  logic    s_valid, advance;

  assign in_item.command        = command;
  assign in_item.timed_out      = timed_out;
  assign in_item.crc_failed     = crc_failed;
  assign in_item.resp_cmd_index = resp_cmd_index;
  assign in_item.resp_word0     = resp_word0;
  assign in_item.resp_word1     = resp_word1;
  assign in_item.resp_word2     = resp_word2;

  // move the held beat through the core when the output register is free
  assign advance   = s_valid && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  sdinit_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  sdinit_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .step     (advance),
    .item     (s_item),
    .res      (core_res)
  );

  sdinit_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (core_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign send_valid    = out_res.send_valid;
  assign cmd_index     = out_res.cmd_index;
  assign cmd_arg       = out_res.cmd_arg;
  assign long_response = out_res.long_response;
  assign finished      = out_res.finished;
  assign status_code   = out_res.status_code;
  assign card_type     = out_res.card_type;
  assign card_address  = out_res.card_address;
  assign capacity_kb   = out_res.capacity_kb;

endmodule

// ----- test/tb_sd_card_init_sequencer.sv -----
`timescale 1ns / 1ps

module tb_sd_card_init_sequencer;
  import sdinit_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [31:0] R1_ERR_MASK = 32'hFDFF_E008;

  typedef enum logic [3:0] {
    P_IDLE, P_GO_IDLE, P_IF_COND, P_FIRST_APP, P_LOOP_APP, P_OP_COND, P_CID,
    P_RCA, P_CSD, P_SELECT, P_WIDTH_APP, P_BUS_WIDTH, P_BLOCKLEN
  } seq_phase_t;

  typedef enum int {F_TIMEOUT, F_CRC, F_INDEX, F_ERR_BITS, F_RESTART, F_NOISE} fault_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic        timed_out;
  logic        crc_failed;
  logic [5:0]  resp_cmd_index;
  logic [31:0] resp_word0;
  logic [31:0] resp_word1;
  logic [31:0] resp_word2;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        send_valid;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic        long_response;
  logic        finished;
  logic [4:0]  status_code;
  logic [1:0]  card_type;
  logic [15:0] card_address;
  logic [31:0] capacity_kb;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // predicted sequencer state
  seq_phase_t  seq_phase = P_IDLE;
  logic [1:0]  card_type_q = TYPE_SDSC_V1;
  logic        hcs_req = 1'b0;
  logic [15:0] rca_q = '0;
  logic [15:0] trials_done = '0;
  logic [31:0] capacity_q = '0;
  logic [15:0] trials_limit = TRIALS_RESET;

  result_t     expected_cmds[$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  logic        stalls_on = 1'b1;
  logic        rx_hold = 1'b0;

  sd_card_init_sequencer uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (stalls_on) begin
      out_ready <= ($urandom_range(99) >= 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [4:0] r1_status(logic [5:0] want_idx, item_t it);
    logic [31:0] errs;
    int rank;
    if (it.timed_out) return ST_TIMEOUT;
    if (it.crc_failed) return ST_CRC;
    if (it.resp_cmd_index != want_idx) return ST_INDEX;
    errs = it.resp_word0 & R1_ERR_MASK;
    rank = 0;
    // highest flagged bit wins, codes count up through the mask
    for (int b = 31; b >= 0; b--) begin
      if (R1_ERR_MASK[b]) begin
        if (errs[b]) return ST_R1_BASE + 5'(rank);
        rank++;
      end
    end
    return ST_OK;
  endfunction

  function automatic logic [4:0] r6_status(item_t it);
    if (it.timed_out) return ST_TIMEOUT;
    if (it.crc_failed) return ST_CRC;
    if (it.resp_cmd_index != CMD_SEND_RCA) return ST_INDEX;
    if (it.resp_word0[13]) return ST_GENERAL;
    if (it.resp_word0[14]) return ST_ILLEGAL;
    if (it.resp_word0[15]) return ST_CMD_CRC;
    return ST_OK;
  endfunction

  function automatic logic [31:0] csd_size_kb(logic [31:0] w0, logic [31:0] w1,
                                              logic [31:0] w2, logic [31:0] prev);
    logic [31:0] blocks;
    int shift;
    blocks = {20'd0, w1[9:0], w2[31:30]} + 32'd1;
    shift = int'(w2[17:15]) + int'(w1[19:16]) - 8;
    case (w0[31:30])
      CSD_V1: begin
        if (shift >= 0) return blocks << shift;
        return blocks >> (-shift);
      end
      CSD_V2: return {10'd0, w1[5:0], w2[31:16]} * 32'd512;
      default: return prev;
    endcase
  endfunction

  function automatic result_t issue_cmd(logic [5:0] idx, logic [31:0] arg, logic lng);
    result_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.cmd_index = idx;
    r.cmd_arg = arg;
    r.long_response = lng;
    return r;
  endfunction

  function automatic result_t end_sequence(logic [4:0] code);
    result_t r;
    r = '0;
    r.finished = 1'b1;
    r.status_code = code;
    return r;
  endfunction

  function automatic result_t advance_sequencer(item_t it);
    result_t r;
    logic [4:0] st;
    seq_phase_t nxt;
    r = '0;
    nxt = seq_phase;
    if (it.command == IN_START) begin
      card_type_q = TYPE_SDSC_V1;
      hcs_req = 1'b0;
      rca_q = '0;
      trials_done = '0;
      capacity_q = '0;
      r = issue_cmd(CMD_GO_IDLE, '0, 1'b0);
      nxt = P_GO_IDLE;
    end else begin
      case (seq_phase)
        P_GO_IDLE: begin
          if (it.timed_out) begin
            r = end_sequence(ST_TIMEOUT);
          end else begin
            r = issue_cmd(CMD_SEND_IF_COND, ARG_IF_COND, 1'b0);
            nxt = P_IF_COND;
          end
        end
        P_IF_COND: begin
          // no answer to the interface condition means a v1.1 card
          if (!it.timed_out) begin
            card_type_q = TYPE_SDSC_V2;
            hcs_req = 1'b1;
          end
          r = issue_cmd(CMD_APP, '0, 1'b0);
          nxt = P_FIRST_APP;
        end
        P_FIRST_APP: begin
          st = r1_status(CMD_APP, it);
          if (st != ST_OK) begin
            r = end_sequence(st);
          end else if (trials_done >= trials_limit) begin
            r = end_sequence(ST_VOLTAGE);
          end else begin
            r = issue_cmd(CMD_APP, '0, 1'b0);
            nxt = P_LOOP_APP;
          end
        end
        P_LOOP_APP: begin
          st = r1_status(CMD_APP, it);
          if (st != ST_OK) begin
            r = end_sequence(st);
          end else begin
            r = issue_cmd(ACMD_SEND_OP_COND, ARG_OP_COND | (hcs_req ? ARG_HCS : '0), 1'b0);
            nxt = P_OP_COND;
          end
        end
        P_OP_COND: begin
          if (it.timed_out) begin
            r = end_sequence(ST_TIMEOUT);
          end else begin
            if (trials_done != TRIALS_SAT) trials_done++;
            // a ready card wins even on the last allowed trial
            if (it.resp_word0[31]) begin
              if (it.resp_word0[30]) card_type_q = TYPE_SDHC;
              r = issue_cmd(CMD_ALL_SEND_CID, '0, 1'b1);
              nxt = P_CID;
            end else if (trials_done >= trials_limit) begin
              r = end_sequence(ST_VOLTAGE);
            end else begin
              r = issue_cmd(CMD_APP, '0, 1'b0);
              nxt = P_LOOP_APP;
            end
          end
        end
        P_CID: begin
          if (it.timed_out) begin
            r = end_sequence(ST_TIMEOUT);
          end else if (it.crc_failed) begin
            r = end_sequence(ST_CRC);
          end else begin
            r = issue_cmd(CMD_SEND_RCA, '0, 1'b0);
            nxt = P_RCA;
          end
        end
        P_RCA: begin
          st = r6_status(it);
          if (st != ST_OK) begin
            r = end_sequence(st);
          end else begin
            rca_q = it.resp_word0[31:16];
            r = issue_cmd(CMD_SEND_CSD, {rca_q, 16'h0}, 1'b1);
            nxt = P_CSD;
          end
        end
        P_CSD: begin
          if (it.timed_out) begin
            r = end_sequence(ST_TIMEOUT);
          end else if (it.crc_failed) begin
            r = end_sequence(ST_CRC);
          end else begin
            capacity_q = csd_size_kb(it.resp_word0, it.resp_word1, it.resp_word2, capacity_q);
            r = issue_cmd(CMD_SELECT, {rca_q, 16'h0}, 1'b0);
            nxt = P_SELECT;
          end
        end
        P_SELECT: begin
          r = issue_cmd(CMD_APP, {rca_q, 16'h0}, 1'b0);
          nxt = P_WIDTH_APP;
        end
        P_WIDTH_APP: begin
          st = r1_status(CMD_APP, it);
          if (st != ST_OK) begin
            r = end_sequence(st);
          end else begin
            r = issue_cmd(ACMD_BUS_WIDTH, ARG_BUS_WIDE, 1'b0);
            nxt = P_BUS_WIDTH;
          end
        end
        P_BUS_WIDTH: begin
          st = r1_status(ACMD_BUS_WIDTH, it);
          if (st != ST_OK) begin
            r = end_sequence(st);
          end else begin
            r = issue_cmd(CMD_SET_BLOCKLEN, ARG_BLOCKLEN, 1'b0);
            nxt = P_BLOCKLEN;
          end
        end
        P_BLOCKLEN: r = end_sequence(r1_status(CMD_SET_BLOCKLEN, it));
        default: ;
      endcase
      if (r.finished) nxt = P_IDLE;
    end
    seq_phase = nxt;
    r.card_type = card_type_q;
    r.card_address = rca_q;
    r.capacity_kb = capacity_q;
    return r;
  endfunction

  // mostly a proper answer to the command in flight, sometimes a broken one
  function automatic item_t next_stimulus(int fault_pct);
    item_t it;
    int b;
    it.command = IN_RESPONSE;
    it.timed_out = 1'b0;
    it.crc_failed = 1'($urandom_range(1));
    it.resp_cmd_index = 6'($urandom_range(63));
    it.resp_word0 = $urandom;
    it.resp_word1 = $urandom;
    it.resp_word2 = $urandom;
    case (seq_phase)
      P_IDLE: begin
        it.command = ($urandom_range(99) < 85) ? IN_START : IN_RESPONSE;
        it.timed_out = 1'($urandom_range(1));
        return it;
      end
      P_IF_COND, P_SELECT: it.timed_out = 1'($urandom_range(1));
      P_FIRST_APP, P_LOOP_APP, P_WIDTH_APP: begin
        it.crc_failed = 1'b0;
        it.resp_cmd_index = CMD_APP;
        it.resp_word0 &= ~R1_ERR_MASK;
      end
      P_BUS_WIDTH: begin
        it.crc_failed = 1'b0;
        it.resp_cmd_index = ACMD_BUS_WIDTH;
        it.resp_word0 &= ~R1_ERR_MASK;
      end
      P_BLOCKLEN: begin
        it.crc_failed = 1'b0;
        it.resp_cmd_index = CMD_SET_BLOCKLEN;
        it.resp_word0 &= ~R1_ERR_MASK;
      end
      P_OP_COND: it.resp_word0[31] = ($urandom_range(99) < 35);
      P_CID: it.crc_failed = 1'b0;
      P_RCA: begin
        it.crc_failed = 1'b0;
        it.resp_cmd_index = CMD_SEND_RCA;
        it.resp_word0[15:13] = 3'b000;
      end
      P_CSD: begin
        it.crc_failed = 1'b0;
        if ($urandom_range(9) == 0) it.resp_word0[31] = 1'b1;
        else it.resp_word0[31:30] = $urandom_range(1) ? CSD_V2 : CSD_V1;
      end
      default: ;
    endcase
    if ($urandom_range(99) < fault_pct) begin
      case (fault_t'($urandom_range(F_NOISE)))
        F_TIMEOUT: it.timed_out = 1'b1;
        F_CRC: it.crc_failed = 1'b1;
        F_INDEX: it.resp_cmd_index = 6'($urandom_range(63));
        F_ERR_BITS: begin
          if (seq_phase == P_RCA) begin
            it.resp_word0[15:13] = 3'($urandom_range(1, 7));
          end else begin
            do b = $urandom_range(31); while (!R1_ERR_MASK[b]);
            it.resp_word0 = it.resp_word0 | (32'h1 << b) |
                            ($urandom & R1_ERR_MASK & ((32'h1 << b) - 32'h1));
          end
        end
        F_RESTART: it.command = IN_START;
        default: it.resp_word0 = $urandom;
      endcase
    end
    return it;
  endfunction

  function automatic item_t reply(logic [5:0] idx, logic [31:0] w0, logic [31:0] w1 = '0,
                                  logic [31:0] w2 = '0, logic to = 1'b0, logic crc = 1'b0);
    item_t it;
    it.command = IN_RESPONSE;
    it.timed_out = to;
    it.crc_failed = crc;
    it.resp_cmd_index = idx;
    it.resp_word0 = w0;
    it.resp_word1 = w1;
    it.resp_word2 = w2;
    return it;
  endfunction

  function automatic item_t kick_off();
    item_t it;
    it = reply(6'h3f, '1, '1, '1, 1'b1, 1'b1);
    it.command = IN_START;
    return it;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        fail_count++;
      end else begin
        want = expected_cmds.pop_front();
        compare_field("send_valid", 32'(want.send_valid), 32'(send_valid));
        compare_field("cmd_index", 32'(want.cmd_index), 32'(cmd_index));
        compare_field("cmd_arg", want.cmd_arg, cmd_arg);
        compare_field("long_response", 32'(want.long_response), 32'(long_response));
        compare_field("finished", 32'(want.finished), 32'(finished));
        compare_field("status_code", 32'(want.status_code), 32'(status_code));
        compare_field("card_type", 32'(want.card_type), 32'(card_type));
        compare_field("card_address", 32'(want.card_address), 32'(card_address));
        compare_field("capacity_kb", want.capacity_kb, capacity_kb);
      end
    end
  end

  task automatic send_item(input item_t it);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.command;
    timed_out <= it.timed_out;
    crc_failed <= it.crc_failed;
    resp_cmd_index <= it.resp_cmd_index;
    resp_word0 <= it.resp_word0;
    resp_word1 <= it.resp_word1;
    resp_word2 <= it.resp_word2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_cmds.push_back(advance_sequencer(it));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_trials(input logic [15:0] limit);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    trials_limit = limit;
  endtask

  task automatic run_sequences(int count, int fault_pct);
    int sent;
    item_t it;
    sent = 0;
    while (sent < count) begin
      it = next_stimulus(fault_pct);
      // responses while idle leave the sequencer untouched, they don't count
      if (!(seq_phase == P_IDLE && it.command == IN_RESPONSE)) sent++;
      send_item(it);
    end
  endtask

  task automatic hold_receiver(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(reply(CMD_APP, '1, '1, '1));
    // go-idle timeout
    send_item(kick_off());
    send_item(reply(CMD_GO_IDLE, '0, '0, '0, 1'b1));
    // v1.1 card, then top-priority r1 error
    send_item(kick_off());
    send_item(reply(6'h3f, '0));
    send_item(reply(CMD_SEND_IF_COND, '0, '0, '0, 1'b1));
    send_item(reply(CMD_APP, 32'hFFFF_FFFF));
    // full sdhc pass, ending on the lowest-priority r1 error
    send_item(kick_off());
    send_item(reply(CMD_GO_IDLE, '0));
    send_item(reply(CMD_SEND_IF_COND, ARG_IF_COND));
    send_item(reply(CMD_APP, 32'h0000_0020));
    send_item(reply(CMD_APP, '0));
    send_item(reply(ACMD_SEND_OP_COND, 32'h00FF_8000, '0, '0, 1'b0, 1'b1));
    send_item(reply(CMD_APP, '0));
    send_item(reply(6'h3f, 32'hC0FF_8000));
    send_item(reply(CMD_GO_IDLE, '1, '1, '1));
    send_item(reply(CMD_SEND_RCA, 32'hFFFF_1FFF));
    send_item(reply(CMD_GO_IDLE, 32'h4000_0000, 32'h0000_003F, 32'hFFFF_0000));
    send_item(reply(CMD_GO_IDLE, '0, '0, '0, 1'b1, 1'b1));
    send_item(reply(CMD_APP, '0));
    send_item(reply(ACMD_BUS_WIDTH, '0));
    send_item(reply(CMD_SET_BLOCKLEN, 32'h0000_0008));
    // restart in the middle of a sequence
    send_item(kick_off());
    send_item(reply(CMD_GO_IDLE, '0));
    send_item(kick_off());
    wait_idle();
  endtask

  task automatic test_sequences(input logic [15:0] limit, int count, int fault_pct);
    write_trials(limit);
    run_sequences(count, fault_pct);
    wait_idle();
  endtask

  task automatic test_backpressure();
    fork
      hold_receiver(400);
      begin
        gaps_on = 1'b0;
        run_sequences(100, 10);
        gaps_on = 1'b1;
      end
    join
    wait_idle();
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    run_sequences(200, 8);
    wait_idle();
    gaps_on = 1'b1;
    stalls_on <= 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= IN_START;
    timed_out <= 1'b0;
    crc_failed <= 1'b0;
    resp_cmd_index <= '0;
    resp_word0 <= '0;
    resp_word1 <= '0;
    resp_word2 <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_sequences(16'd1, 150, 8);
    test_sequences(16'd2, 150, 8);
    test_sequences(16'($urandom_range(3, 20)), 300, 10);
    test_backpressure();
    test_steady_stream();
    test_sequences(16'hffff, 300, 6);
    test_sequences(16'($urandom_range(1, 65535)), 230, 10);
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
